// ===== rtl/lasq_pkg.sv =====
// Types and constants shared by the lock actuation sequencer files.
`default_nettype none

package lasq_pkg;

  localparam int unsigned CfgAddrBits = 5;
  localparam int unsigned CfgDataBits = 32;

  localparam logic [2:0] REG_PULL_TIME     = 3'd0;
  localparam logic [2:0] REG_PUSH_TIME     = 3'd1;
  localparam logic [2:0] REG_OPEN_TIME     = 3'd2;
  localparam logic [2:0] REG_SPRING_ENABLE = 3'd3;
  localparam logic [2:0] REG_SPRING_LEVEL  = 3'd4;
  localparam logic [2:0] REG_LOCK_KIND     = 3'd5;

  localparam logic [7:0]  TIME_RESET      = 8'd100;
  localparam logic [10:0] SPRING_LEVEL_MAX = 11'd1599;

  localparam logic [1:0] DRIVE_NONE    = 2'd0;
  localparam logic [1:0] DRIVE_REVERSE = 2'd1;
  localparam logic [1:0] DRIVE_FORWARD = 2'd2;
  localparam logic [1:0] DRIVE_STOP    = 2'd3;

  localparam logic [1:0] LATCH_NONE  = 2'd0;
  localparam logic [1:0] LATCH_START = 2'd1;
  localparam logic [1:0] LATCH_STOP  = 2'd2;

  localparam logic [1:0] SPRING_NONE  = 2'd0;
  localparam logic [1:0] SPRING_START = 2'd1;
  localparam logic [1:0] SPRING_STOP  = 2'd2;

  localparam logic [2:0] PHASE_CHECK_PULL = 3'd0;
  localparam logic [2:0] PHASE_PULL       = 3'd1;
  localparam logic [2:0] PHASE_CHECK_PUSH = 3'd2;
  localparam logic [2:0] PHASE_PUSH       = 3'd3;
  localparam logic [2:0] PHASE_CHECK_OPEN = 3'd4;
  localparam logic [2:0] PHASE_OPEN       = 3'd5;
  localparam logic [2:0] PHASE_IDLE       = 3'd6;

  localparam logic [2:0] BOOK_PULL = 3'b001;
  localparam logic [2:0] BOOK_PUSH = 3'b010;
  localparam logic [2:0] BOOK_OPEN = 3'b100;

  typedef enum logic [6:0] {
    STEP_CHECK_PULL = 7'b0000001,
    STEP_PULL       = 7'b0000010,
    STEP_CHECK_PUSH = 7'b0000100,
    STEP_PUSH       = 7'b0001000,
    STEP_CHECK_OPEN = 7'b0010000,
    STEP_OPEN       = 7'b0100000,
    STEP_IDLE       = 7'b1000000
  } step_e;

  typedef struct packed {
    logic       book_write;
    logic [2:0] book_value;
    logic       upper_at_open;
    logic       lower_at_open;
  } lasq_in_t;

  typedef struct packed {
    logic [1:0]  main_drive_cmd;
    logic [1:0]  latch_cmd;
    logic [1:0]  spring_cmd;
    logic [10:0] spring_drive;
    logic [2:0]  phase;
    logic [2:0]  pending;
  } lasq_out_t;

  typedef struct packed {
    logic [7:0]  pull_time;
    logic [7:0]  push_time;
    logic [7:0]  open_time;
    logic        spring_enable;
    logic [10:0] spring_level;
    logic        lock_kind;
  } lasq_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/lasq_regs.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none

module lasq_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lasq_pkg::CfgAddrBits-1:0]    paddr,
  input  logic [lasq_pkg::CfgDataBits-1:0]    pwdata,
  output logic [lasq_pkg::CfgDataBits-1:0]    prdata,
  output logic                                pready,
  output lasq_pkg::lasq_cfg_t                 cfg_o
);
  import lasq_pkg::*;

  lasq_cfg_t  cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CfgAddrBits-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_PULL_TIME:     cfg_d.pull_time     = pwdata[7:0];
        REG_PUSH_TIME:     cfg_d.push_time     = pwdata[7:0];
        REG_OPEN_TIME:     cfg_d.open_time     = pwdata[7:0];
        REG_SPRING_ENABLE: cfg_d.spring_enable = pwdata[0];
        REG_SPRING_LEVEL:  cfg_d.spring_level  = pwdata[10:0];
        REG_LOCK_KIND:     cfg_d.lock_kind     = pwdata[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pull_time     <= TIME_RESET;
      cfg_q.push_time     <= TIME_RESET;
      cfg_q.open_time     <= TIME_RESET;
      cfg_q.spring_enable <= 1'b0;
      cfg_q.spring_level  <= '0;
      cfg_q.lock_kind     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_PULL_TIME:     prdata = CfgDataBits'(cfg_q.pull_time);
      REG_PUSH_TIME:     prdata = CfgDataBits'(cfg_q.push_time);
      REG_OPEN_TIME:     prdata = CfgDataBits'(cfg_q.open_time);
      REG_SPRING_ENABLE: prdata = CfgDataBits'(cfg_q.spring_enable);
      REG_SPRING_LEVEL:  prdata = CfgDataBits'(cfg_q.spring_level);
      REG_LOCK_KIND:     prdata = CfgDataBits'(cfg_q.lock_kind);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/lasq_core.sv =====
// Sequencer state and the single-tick step logic.
`default_nettype none

module lasq_core #(
  parameter int unsigned CountBits = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_en_i,
  input  lasq_pkg::lasq_in_t   item_i,
  input  lasq_pkg::lasq_cfg_t  cfg_i,
  output lasq_pkg::lasq_out_t  result_o
);
  import lasq_pkg::*;

  localparam int unsigned CmpBits = (CountBits > 8) ? CountBits : 8;

  step_e                step_q, step_d;
  logic                 started_q, started_d;
  logic                 active_q, active_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic [2:0]           book_q, book_d;

  logic [2:0]           book_eff;
  logic [CountBits-1:0] cnt_inc;
  logic [7:0]           limit;
  logic                 past_limit;
  logic                 started_now;
  logic                 stopped_now;
  logic                 pos_open;
  logic [10:0]          level_sat;
  logic [2:0]           phase_num;

  assign book_eff   = item_i.book_write ? item_i.book_value : book_q;
  assign cnt_inc    = cnt_q + CountBits'(1);
  assign past_limit = CmpBits'(cnt_inc) > CmpBits'(limit);
  assign pos_open   = cfg_i.lock_kind ? item_i.upper_at_open : item_i.lower_at_open;
  assign level_sat  = (cfg_i.spring_level > SPRING_LEVEL_MAX) ? SPRING_LEVEL_MAX
                                                              : cfg_i.spring_level;

  always_comb begin
    case (step_q)
      STEP_PULL: limit = cfg_i.pull_time;
      STEP_PUSH: limit = cfg_i.push_time;
      default:   limit = cfg_i.open_time;
    endcase
  end

  always_comb begin
    step_d      = step_q;
    started_d   = started_q;
    active_d    = active_q;
    cnt_d       = cnt_q;
    book_d      = book_eff;
    started_now = 1'b0;
    stopped_now = 1'b0;
    case (step_q)
      STEP_CHECK_PULL, STEP_CHECK_PUSH, STEP_CHECK_OPEN: begin
        cnt_d     = '0;
        started_d = 1'b0;
        active_d  = 1'b0;
        case (step_q)
          STEP_CHECK_PULL: begin
            if ((book_eff & BOOK_PULL) != 3'b000) begin
              active_d = 1'b1;
              step_d   = STEP_PULL;
              book_d   = book_eff & ~BOOK_PULL;
            end else begin
              step_d = STEP_CHECK_PUSH;
            end
          end
          STEP_CHECK_PUSH: begin
            if ((book_eff & BOOK_PUSH) != 3'b000) begin
              active_d = 1'b1;
              step_d   = STEP_PUSH;
              book_d   = book_eff & ~BOOK_PUSH;
            end else begin
              step_d = STEP_CHECK_OPEN;
            end
          end
          default: begin
            if ((book_eff & BOOK_OPEN) != 3'b000) begin
              active_d = 1'b1;
              step_d   = STEP_OPEN;
              book_d   = book_eff & ~BOOK_OPEN;
            end else begin
              step_d = STEP_IDLE;
            end
          end
        endcase
      end
      STEP_PULL, STEP_PUSH, STEP_OPEN: begin
        if (active_q) begin
          if (!started_q) begin
            started_d   = 1'b1;
            started_now = 1'b1;
          end else begin
            cnt_d = cnt_inc;
            if (past_limit) begin
              active_d    = 1'b0;
              stopped_now = 1'b1;
            end
          end
        end else begin
          cnt_d     = '0;
          started_d = 1'b0;
          case (step_q)
            STEP_PULL: step_d = STEP_CHECK_PUSH;
            STEP_PUSH: step_d = STEP_CHECK_OPEN;
            default:   step_d = STEP_IDLE;
          endcase
        end
      end
      default: begin
        if (book_eff != 3'b000) begin
          step_d = STEP_CHECK_PULL;
        end
      end
    endcase
  end

  always_comb begin
    case (step_d)
      STEP_CHECK_PULL: phase_num = PHASE_CHECK_PULL;
      STEP_PULL:       phase_num = PHASE_PULL;
      STEP_CHECK_PUSH: phase_num = PHASE_CHECK_PUSH;
      STEP_PUSH:       phase_num = PHASE_PUSH;
      STEP_CHECK_OPEN: phase_num = PHASE_CHECK_OPEN;
      STEP_OPEN:       phase_num = PHASE_OPEN;
      default:         phase_num = PHASE_IDLE;
    endcase
  end

  always_comb begin
    result_o                = '0;
    result_o.main_drive_cmd = DRIVE_NONE;
    result_o.latch_cmd      = LATCH_NONE;
    result_o.spring_cmd     = SPRING_NONE;
    case (step_q)
      STEP_PULL: begin
        if (started_now) result_o.main_drive_cmd = DRIVE_REVERSE;
        if (stopped_now) result_o.main_drive_cmd = DRIVE_STOP;
      end
      STEP_PUSH: begin
        if (started_now) result_o.main_drive_cmd = DRIVE_FORWARD;
        if (stopped_now) result_o.main_drive_cmd = DRIVE_STOP;
      end
      STEP_OPEN: begin
        if (started_now) begin
          result_o.latch_cmd = LATCH_START;
          if (cfg_i.spring_enable) result_o.spring_cmd = SPRING_START;
        end
        if (stopped_now) begin
          result_o.latch_cmd = LATCH_STOP;
          if (cfg_i.spring_enable && !pos_open) result_o.spring_cmd = SPRING_STOP;
        end
      end
      default: result_o.main_drive_cmd = DRIVE_NONE;
    endcase
    result_o.spring_drive = (result_o.spring_cmd == SPRING_START) ? level_sat : '0;
    result_o.phase        = phase_num;
    result_o.pending      = book_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= STEP_CHECK_PULL;
      started_q <= 1'b0;
      active_q  <= 1'b0;
      cnt_q     <= '0;
      book_q    <= '0;
    end else if (step_en_i) begin
      step_q    <= step_d;
      started_q <= started_d;
      active_q  <= active_d;
      cnt_q     <= cnt_d;
      book_q    <= book_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lock_actuation_sequencer_top.sv =====
// Lock actuation sequencer: input register, step logic, result register.
// A word accepted into the input register passes through the step logic into the result
// register, which drives the outputs (two registers).
// Throughput: one word per cycle while the result register is not stalled; the input
// register refills while a result waits. in_stall_o rises only when the input register
// is full and the result register is stalled. Reset clears the sequencer state, both
// valid flags and the registers to their documented values; no clearing pass is needed.
`default_nettype none

module lock_actuation_sequencer_top #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  lasq_pkg::lasq_in_t                in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output lasq_pkg::lasq_out_t               out_word_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lasq_pkg::CfgAddrBits-1:0]  paddr,
  input  logic [lasq_pkg::CfgDataBits-1:0]  pwdata,
  output logic [lasq_pkg::CfgDataBits-1:0]  prdata,
  output logic                              pready
);
  import lasq_pkg::*;

  lasq_in_t  in_q;
  logic      in_vld_q;
  lasq_out_t out_q;
  logic      out_vld_q;
  lasq_out_t result;
  lasq_cfg_t cfg;
  logic      out_adv;
  logic      step_en;

  assign out_adv    = !out_vld_q || !out_stall_i;
  assign step_en    = in_vld_q && out_adv;
  assign in_stall_o = in_vld_q && !out_adv;

  lasq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lasq_core #(
    .CountBits (COUNT_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .item_i    (in_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/lasq_checker.sv =====
// Port-level checks for the lock actuation sequencer and their bind.
`default_nettype none

module lasq_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input lasq_pkg::lasq_out_t  out_word_o
);
  import lasq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  a_drive_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.spring_cmd != SPRING_START) |-> out_word_o.spring_drive == '0)
    else $error("spring level without spring start");

  a_one_actuator: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.main_drive_cmd != DRIVE_NONE)
      |-> out_word_o.latch_cmd == LATCH_NONE && out_word_o.spring_cmd == SPRING_NONE)
    else $error("main drive and latch commanded together");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.phase == PHASE_IDLE)
      |-> out_word_o.main_drive_cmd == DRIVE_NONE && out_word_o.latch_cmd == LATCH_NONE
          && out_word_o.spring_cmd == SPRING_NONE)
    else $error("command issued in idle phase");

endmodule

bind lock_actuation_sequencer_top lasq_checker u_lasq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire

// ===== dv/lock_actuation_sequencer_top_tb.sv =====
// Testbench for the lock actuation sequencer: predicts every result word and checks it.
`timescale 1ns / 100ps

module lock_actuation_sequencer_top_tb;
  import lasq_pkg::*;

  localparam int unsigned CountBits = 8;
  localparam int WatchdogLimit = 3000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  lasq_in_t               in_word_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  lasq_out_t              out_word_o;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CfgAddrBits-1:0] paddr = '0;
  logic [CfgDataBits-1:0] pwdata = '0;
  logic [CfgDataBits-1:0] prdata;
  logic                   pready;

  // sequencer shadow state
  logic [2:0]           seq_phase = PHASE_CHECK_PULL;
  logic                 started = 1'b0;
  logic                 act_on = 1'b0;
  logic [CountBits-1:0] ticks = '0;
  logic [2:0]           booked = '0;
  lasq_cfg_t            cfg;

  lasq_out_t expected_words[$];
  lasq_out_t want_word;
  int        mismatch_cnt = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        hold_cycles = 0;
  int        quiet_cycles = 0;

  lock_actuation_sequencer_top #(
    .COUNT_BITS(CountBits)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #6 clk_i = ~clk_i;

  function automatic void report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void check_booking(input logic [2:0] mask, input logic [2:0] run_phase,
                                        input logic [2:0] skip_phase);
    ticks = '0;
    started = 1'b0;
    if ((booked & mask) != '0) begin
      act_on = 1'b1;
      seq_phase = run_phase;
      booked = booked & ~mask;
    end else begin
      act_on = 1'b0;
      seq_phase = skip_phase;
    end
  endfunction

  function automatic lasq_out_t step_sequencer(input lasq_in_t w);
    lasq_out_t  r;
    logic       start;
    logic       stop;
    logic       pos_open;
    logic [7:0] lim;
    r = '0;
    start = 1'b0;
    stop = 1'b0;
    if (w.book_write) booked = w.book_value;
    case (seq_phase)
      PHASE_CHECK_PULL: check_booking(BOOK_PULL, PHASE_PULL, PHASE_CHECK_PUSH);
      PHASE_CHECK_PUSH: check_booking(BOOK_PUSH, PHASE_PUSH, PHASE_CHECK_OPEN);
      PHASE_CHECK_OPEN: check_booking(BOOK_OPEN, PHASE_OPEN, PHASE_IDLE);
      PHASE_PULL, PHASE_PUSH, PHASE_OPEN: begin
        lim = (seq_phase == PHASE_PULL) ? cfg.pull_time :
              (seq_phase == PHASE_PUSH) ? cfg.push_time : cfg.open_time;
        if (!act_on) begin
          ticks = '0;
          started = 1'b0;
          seq_phase = seq_phase + 3'd1;
        end else if (!started) begin
          started = 1'b1;
          start = 1'b1;
        end else begin
          ticks = ticks + 1'b1;
          if (ticks > lim) begin
            act_on = 1'b0;
            stop = 1'b1;
          end
        end
      end
      default: begin
        if (booked != '0) seq_phase = PHASE_CHECK_PULL;
      end
    endcase
    if (start || stop) begin
      case (seq_phase)
        PHASE_PULL: r.main_drive_cmd = start ? DRIVE_REVERSE : DRIVE_STOP;
        PHASE_PUSH: r.main_drive_cmd = start ? DRIVE_FORWARD : DRIVE_STOP;
        default: begin
          pos_open = cfg.lock_kind ? w.upper_at_open : w.lower_at_open;
          r.latch_cmd = start ? LATCH_START : LATCH_STOP;
          if (cfg.spring_enable && (start || !pos_open))
            r.spring_cmd = start ? SPRING_START : SPRING_STOP;
        end
      endcase
    end
    if (r.spring_cmd == SPRING_START)
      r.spring_drive = (cfg.spring_level > SPRING_LEVEL_MAX) ? SPRING_LEVEL_MAX : cfg.spring_level;
    r.phase = seq_phase;
    r.pending = booked;
    return r;
  endfunction

  function automatic logic [7:0] pick_time();
    case ($urandom_range(9))
      0: return 8'd254;
      1: return 8'd0;
      default: return 8'($urandom_range(6));
    endcase
  endfunction

  task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] data,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(input logic [2:0] idx);
    logic [31:0] got;
    logic [31:0] want;
    case (idx)
      REG_PULL_TIME:     want = 32'(cfg.pull_time);
      REG_PUSH_TIME:     want = 32'(cfg.push_time);
      REG_OPEN_TIME:     want = 32'(cfg.open_time);
      REG_SPRING_ENABLE: want = 32'(cfg.spring_enable);
      REG_SPRING_LEVEL:  want = 32'(cfg.spring_level);
      default:           want = 32'(cfg.lock_kind);
    endcase
    apb_access(1'b0, idx, '0, got);
    if (got !== want)
      report_mismatch($sformatf("register %0d read exp %0h got %0h", idx, want, got));
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] unused;
    case (idx)
      REG_PULL_TIME:     cfg.pull_time = val[7:0];
      REG_PUSH_TIME:     cfg.push_time = val[7:0];
      REG_OPEN_TIME:     cfg.open_time = val[7:0];
      REG_SPRING_ENABLE: cfg.spring_enable = val[0];
      REG_SPRING_LEVEL:  cfg.spring_level = val[10:0];
      default:           cfg.lock_kind = val[0];
    endcase
    apb_access(1'b1, idx, val, unused);
    check_reg(idx);
  endtask

  task automatic send_tick(input logic bw, input logic [2:0] bv, input logic up, input logic lo);
    lasq_in_t w;
    w.book_write = bw;
    w.book_value = bv;
    w.upper_at_open = up;
    w.lower_at_open = lo;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    expected_words.push_back(step_sequencer(w));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_register_reset();
    for (int r = REG_PULL_TIME; r <= REG_LOCK_KIND; r++) check_reg(3'(r));
  endtask

  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    set_reg(REG_PULL_TIME, 32'd0);
    set_reg(REG_PUSH_TIME, 32'd1);
    set_reg(REG_OPEN_TIME, 32'd0);
    set_reg(REG_SPRING_ENABLE, 32'd1);
    set_reg(REG_SPRING_LEVEL, 32'(SPRING_LEVEL_MAX));
    set_reg(REG_LOCK_KIND, 32'd0);
    repeat (3) send_tick(1'b0, BOOK_PULL | BOOK_PUSH | BOOK_OPEN, 1'b1, 1'b1);
    send_tick(1'b1, BOOK_PULL | BOOK_PUSH | BOOK_OPEN, 1'b1, 1'b0);
    repeat (13) send_tick(1'b0, 3'b000, 1'b1, 1'b0);
    drain_results();
    // spring level above range, upper lock checked, rebook pull mid phase
    set_reg(REG_SPRING_LEVEL, 32'd2047);
    set_reg(REG_LOCK_KIND, 32'd1);
    set_reg(REG_OPEN_TIME, 32'd2);
    send_tick(1'b1, BOOK_OPEN, 1'b0, 1'b1);
    repeat (4) send_tick(1'b0, 3'b000, 1'b0, 1'b1);
    send_tick(1'b1, BOOK_PULL, 1'b0, 1'b1);
    repeat (8) send_tick(1'b0, 3'b000, 1'b0, 1'b1);
    drain_results();
  endtask

  task automatic test_counter_wrap();
    set_reg(REG_PULL_TIME, 32'd255);
    send_tick(1'b1, BOOK_PULL, 1'b0, 1'b0);
    repeat (270) send_tick(1'b0, 3'($urandom_range(7)), 1'($urandom), 1'($urandom));
    drain_results();
    set_reg(REG_PULL_TIME, 32'd0);
    repeat (8) send_tick(1'b0, 3'($urandom_range(7)), 1'($urandom), 1'($urandom));
    drain_results();
  endtask

  task automatic test_random(input int sender_idle, input int receiver_stall);
    logic        fresh;
    logic [31:0] lvl;
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    repeat (5) begin
      drain_results();
      case ($urandom_range(3))
        0: lvl = 32'd0;
        1: lvl = 32'(SPRING_LEVEL_MAX);
        2: lvl = 32'd2047;
        default: lvl = 32'($urandom_range(2047));
      endcase
      set_reg(REG_PULL_TIME, 32'(pick_time()));
      set_reg(REG_PUSH_TIME, 32'(pick_time()));
      set_reg(REG_OPEN_TIME, 32'(pick_time()));
      set_reg(REG_SPRING_ENABLE, 32'($urandom_range(1)));
      set_reg(REG_SPRING_LEVEL, lvl);
      set_reg(REG_LOCK_KIND, 32'($urandom_range(1)));
      repeat (50) begin
        fresh = (seq_phase == PHASE_IDLE) && (booked == '0);
        send_tick($urandom_range(99) < (fresh ? 60 : 6), 3'($urandom_range(7)),
                  1'($urandom), 1'($urandom));
      end
    end
    drain_results();
  endtask

  task automatic test_hold_off();
    idle_pct = 0;
    stall_pct = 0;
    set_reg(REG_PULL_TIME, 32'd1);
    set_reg(REG_PUSH_TIME, 32'd0);
    set_reg(REG_OPEN_TIME, 32'd3);
    hold_cycles = 300;
    repeat (40) send_tick($urandom_range(99) < 20, 3'($urandom_range(7)),
                          1'($urandom), 1'($urandom));
    drain_results();
  endtask

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing expected", out_word_o));
      end else begin
        want_word = expected_words.pop_front();
        if (out_word_o.main_drive_cmd !== want_word.main_drive_cmd)
          report_mismatch($sformatf("main_drive_cmd exp %0d got %0d",
                                    want_word.main_drive_cmd, out_word_o.main_drive_cmd));
        if (out_word_o.latch_cmd !== want_word.latch_cmd)
          report_mismatch($sformatf("latch_cmd exp %0d got %0d",
                                    want_word.latch_cmd, out_word_o.latch_cmd));
        if (out_word_o.spring_cmd !== want_word.spring_cmd)
          report_mismatch($sformatf("spring_cmd exp %0d got %0d",
                                    want_word.spring_cmd, out_word_o.spring_cmd));
        if (out_word_o.spring_drive !== want_word.spring_drive)
          report_mismatch($sformatf("spring_drive exp %0d got %0d",
                                    want_word.spring_drive, out_word_o.spring_drive));
        if (out_word_o.phase !== want_word.phase)
          report_mismatch($sformatf("phase exp %0d got %0d",
                                    want_word.phase, out_word_o.phase));
        if (out_word_o.pending !== want_word.pending)
          report_mismatch($sformatf("pending exp %0d got %0d",
                                    want_word.pending, out_word_o.pending));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    cfg.pull_time = TIME_RESET;
    cfg.push_time = TIME_RESET;
    cfg.open_time = TIME_RESET;
    cfg.spring_enable = 1'b0;
    cfg.spring_level = '0;
    cfg.lock_kind = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_register_reset();
    test_directed();
    test_counter_wrap();
    test_random(21, 88);
    test_random(88, 21);
    test_random(0, 0);
    test_hold_off();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lasq_pkg.sv
rtl/lasq_regs.sv
rtl/lasq_core.sv
rtl/lock_actuation_sequencer_top.sv
rtl/lasq_checker.sv
dv/lock_actuation_sequencer_top_tb.sv
